[src/boundary_tag_heap_allocator_unit_assert.svh]
// Assertion helpers used by the allocator controller.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define BTHALLOC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BTHALLOC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bthalloc_pkg.sv]
package bthalloc_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [12:0] request_size;
    logic [11:0] release_offset;
  } req_t;

  typedef struct packed {
    logic [11:0] payload_offset;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [9:0] {
    S_INIT0 = 10'b0000000001,
    S_INIT1 = 10'b0000000010,
    S_IDLE  = 10'b0000000100,
    S_READ  = 10'b0000001000,
    S_EVAL  = 10'b0000010000,
    S_NREAD = 10'b0000100000,
    S_NEVAL = 10'b0001000000,
    S_FPLAN = 10'b0010000000,
    S_WRITE = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic       start;
    logic       rd;
    logic       rd_next;
    logic       step;
    logic       hold_sz;
    logic       plan_alloc;
    logic       plan_free;
    logic       merge;
    logic       wr;
    logic       init_wr;
    logic       init_last;
    logic       res_en;
    logic [1:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic addr_bad;
    logic at_end;
    logic bad_tag;
    logic fits;
    logic hit;
    logic used;
    logic past;
    logic next_in;
    logic wr_last;
  } sts_t;

endpackage

[src/bthalloc_ram.sv]
module bthalloc_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bthalloc_dp.sv]
module bthalloc_dp #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bthalloc_pkg::req_t  req_i,
  input  bthalloc_pkg::cmd_t  cmd_i,
  output bthalloc_pkg::sts_t  sts_o,
  output bthalloc_pkg::rsp_t  rsp_o
);

  localparam int Span  = HEAP_BYTES - (HEAP_BYTES % 8);
  localparam int Words = HEAP_BYTES / 4;
  localparam int Aw    = (Words > 1) ? $clog2(Words) : 1;
  localparam int OffW  = $clog2(HEAP_BYTES) + 1;
  localparam int CmpW  = ((OffW > 14) ? OffW : 14) + 1;
  localparam int TgtW  = ((OffW > 12) ? OffW : 12) + 1;
  localparam int Last  = (Span - 4) / 4;

  logic [OffW-1:0] curr_q, prev_q, sz_q, target_q;
  logic            prev_free_q, have_prev_q, is_free_q, addr_bad_q;
  logic [13:0]     total_q;
  logic [Aw-1:0]   wa_q [4];
  logic [OffW-1:0] wd_q [4];
  logic [1:0]      widx_q, wlast_q;
  bthalloc_pkg::rsp_t rsp_q;

  logic [OffW-1:0] rdata, sz, nsz, curr_sz, next_off, start, fsize, room;
  logic [OffW-1:0] a_foot, t_head, w_foot, f_foot;
  logic [CmpW-1:0] sz_c, tot_c;
  logic            we;
  logic [Aw-1:0]   waddr, raddr;
  logic [OffW-1:0] wdata;
  logic [TgtW-1:0] p_ext;
  logic            nxt_ok;

  bthalloc_ram #(.Width(OffW), .Depth(Words)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign sz       = rdata & ~OffW'(7);
  assign nsz      = sz;
  assign curr_sz  = curr_q + sz;
  assign next_off = curr_q + sz_q;
  assign sz_c     = CmpW'(sz);
  assign tot_c    = CmpW'(total_q);
  assign room     = OffW'(Span) - next_off;
  assign nxt_ok   = !rdata[0] && (nsz != '0) && (nsz <= room);
  assign p_ext    = TgtW'(req_i.release_offset);

  // Tag byte offsets for the planned writes.
  assign a_foot = curr_q + OffW'(total_q) - OffW'(4);
  assign t_head = curr_q + OffW'(total_q);
  assign w_foot = curr_sz - OffW'(4);
  assign f_foot = start + fsize - OffW'(4);

  assign raddr = cmd_i.rd_next ? next_off[Aw+1:2] : curr_q[Aw+1:2];

  // Free block bounds after merging with the neighbors that qualify.
  always_comb begin
    start = target_q;
    fsize = sz_q;
    if (have_prev_q && prev_free_q) begin
      start = prev_q;
      fsize = sz_q + (target_q - prev_q);
    end
    if (cmd_i.merge && nxt_ok) begin
      fsize = fsize + nsz;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = wa_q[widx_q];
    wdata = wd_q[widx_q];
    if (cmd_i.init_wr) begin
      we    = 1'b1;
      waddr = cmd_i.init_last ? Aw'(Last) : '0;
      wdata = OffW'(Span);
    end else if (cmd_i.wr) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q      <= '0;
      wlast_q     <= '0;
      have_prev_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        have_prev_q <= 1'b0;
      end else if (cmd_i.step) begin
        have_prev_q <= 1'b1;
      end
      if (cmd_i.plan_alloc || cmd_i.plan_free) begin
        widx_q <= '0;
      end else if (cmd_i.wr) begin
        widx_q <= widx_q + 2'd1;
      end
      if (cmd_i.plan_alloc) begin
        wlast_q <= (sz_c > tot_c + CmpW'(16)) ? 2'd3 : 2'd1;
      end else if (cmd_i.plan_free) begin
        wlast_q <= 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      curr_q     <= '0;
      is_free_q  <= (req_i.req_type == bthalloc_pkg::REQ_FREE);
      total_q    <= (14'(req_i.request_size) + 14'd15) & ~14'd7;
      addr_bad_q <= (req_i.release_offset < 12'd4) || (req_i.release_offset[2:0] != 3'd4)
                    || (p_ext >= TgtW'(Span));
      target_q   <= OffW'(p_ext - TgtW'(4));
    end
    if (cmd_i.step) begin
      prev_q      <= curr_q;
      prev_free_q <= !rdata[0];
      curr_q      <= curr_sz;
    end
    if (cmd_i.hold_sz) begin
      sz_q <= sz;
    end
    if (cmd_i.plan_alloc) begin
      if (sz_c > tot_c + CmpW'(16)) begin
        wa_q[0] <= curr_q[Aw+1:2];
        wd_q[0] <= OffW'(total_q) | OffW'(1);
        wa_q[1] <= a_foot[Aw+1:2];
        wd_q[1] <= OffW'(total_q) | OffW'(1);
        wa_q[2] <= t_head[Aw+1:2];
        wd_q[2] <= sz - OffW'(total_q);
        wa_q[3] <= w_foot[Aw+1:2];
        wd_q[3] <= sz - OffW'(total_q);
      end else begin
        wa_q[0] <= curr_q[Aw+1:2];
        wd_q[0] <= sz | OffW'(1);
        wa_q[1] <= w_foot[Aw+1:2];
        wd_q[1] <= sz | OffW'(1);
      end
    end
    if (cmd_i.plan_free) begin
      wa_q[0] <= start[Aw+1:2];
      wd_q[0] <= fsize;
      wa_q[1] <= f_foot[Aw+1:2];
      wd_q[1] <= fsize;
    end
    if (cmd_i.res_en) begin
      rsp_q.status <= cmd_i.res_code;
      if (!is_free_q && cmd_i.res_code == bthalloc_pkg::ST_OK) begin
        rsp_q.payload_offset <= 12'(TgtW'(curr_q) + TgtW'(4));
      end else begin
        rsp_q.payload_offset <= '0;
      end
    end
  end

  assign sts_o.is_free  = is_free_q;
  assign sts_o.addr_bad = addr_bad_q;
  assign sts_o.at_end   = (curr_q >= OffW'(Span));
  assign sts_o.bad_tag  = (sz == '0) || (sz > OffW'(Span) - curr_q);
  assign sts_o.fits     = !rdata[0] && (sz_c >= tot_c);
  assign sts_o.hit      = (curr_q == target_q);
  assign sts_o.used     = rdata[0];
  assign sts_o.past     = (curr_q > target_q);
  assign sts_o.next_in  = (curr_sz < OffW'(Span));
  assign sts_o.wr_last  = (widx_q == wlast_q);
  assign rsp_o          = rsp_q;

endmodule

[src/bthalloc_ctrl.sv]
`include "boundary_tag_heap_allocator_unit_assert.svh"

module bthalloc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bthalloc_pkg::sts_t sts_i,
  output bthalloc_pkg::cmd_t cmd_o
);

  bthalloc_pkg::state_e state_q, state_d;
  logic [1:0] code_q, code_d;
  logic       out_valid_q;
  logic [1:0] fail_code;

  assign fail_code  = sts_i.is_free ? bthalloc_pkg::ST_BAD_ADDR : bthalloc_pkg::ST_NO_FIT;
  assign in_ready_o = (state_q == bthalloc_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.res_code = code_q;
    case (state_q)
      bthalloc_pkg::S_INIT0: begin
        cmd_o.init_wr = 1'b1;
        state_d = bthalloc_pkg::S_INIT1;
      end
      bthalloc_pkg::S_INIT1: begin
        cmd_o.init_wr   = 1'b1;
        cmd_o.init_last = 1'b1;
        state_d = bthalloc_pkg::S_IDLE;
      end
      bthalloc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = bthalloc_pkg::S_READ;
        end
      end
      bthalloc_pkg::S_READ: begin
        if (sts_i.is_free && sts_i.addr_bad) begin
          code_d  = bthalloc_pkg::ST_BAD_ADDR;
          state_d = bthalloc_pkg::S_RESP;
        end else if (sts_i.at_end) begin
          code_d  = fail_code;
          state_d = bthalloc_pkg::S_RESP;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = bthalloc_pkg::S_EVAL;
        end
      end
      bthalloc_pkg::S_EVAL: begin
        if (sts_i.bad_tag) begin
          code_d  = fail_code;
          state_d = bthalloc_pkg::S_RESP;
        end else if (!sts_i.is_free) begin
          if (sts_i.fits) begin
            cmd_o.plan_alloc = 1'b1;
            code_d  = bthalloc_pkg::ST_OK;
            state_d = bthalloc_pkg::S_WRITE;
          end else begin
            cmd_o.step = 1'b1;
            state_d = bthalloc_pkg::S_READ;
          end
        end else if (sts_i.hit) begin
          if (!sts_i.used) begin
            code_d  = bthalloc_pkg::ST_BAD_ADDR;
            state_d = bthalloc_pkg::S_RESP;
          end else begin
            cmd_o.hold_sz = 1'b1;
            state_d = sts_i.next_in ? bthalloc_pkg::S_NREAD : bthalloc_pkg::S_FPLAN;
          end
        end else if (sts_i.past) begin
          code_d  = bthalloc_pkg::ST_BAD_ADDR;
          state_d = bthalloc_pkg::S_RESP;
        end else begin
          cmd_o.step = 1'b1;
          state_d = bthalloc_pkg::S_READ;
        end
      end
      bthalloc_pkg::S_NREAD: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d = bthalloc_pkg::S_NEVAL;
      end
      bthalloc_pkg::S_NEVAL: begin
        cmd_o.plan_free = 1'b1;
        cmd_o.merge     = 1'b1;
        code_d  = bthalloc_pkg::ST_OK;
        state_d = bthalloc_pkg::S_WRITE;
      end
      bthalloc_pkg::S_FPLAN: begin
        cmd_o.plan_free = 1'b1;
        code_d  = bthalloc_pkg::ST_OK;
        state_d = bthalloc_pkg::S_WRITE;
      end
      bthalloc_pkg::S_WRITE: begin
        cmd_o.wr = 1'b1;
        if (sts_i.wr_last) begin
          state_d = bthalloc_pkg::S_RESP;
        end
      end
      bthalloc_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_en = 1'b1;
          state_d = bthalloc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bthalloc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bthalloc_pkg::S_INIT0;
      code_q      <= bthalloc_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      if (cmd_o.res_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `BTHALLOC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "accepted item did not leave idle")
  `BTHALLOC_ASSERT_NOW(a_rise_from_resp, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == bthalloc_pkg::S_RESP, "result shown outside the response step")
  `BTHALLOC_ASSERT_NEXT(a_write_end, clk_i, rst_ni, (state_q == bthalloc_pkg::S_WRITE) && sts_i.wr_last, state_q == bthalloc_pkg::S_RESP, "tag write sequence did not end in response")

endmodule

[src/boundary_tag_heap_allocator_unit.sv]
// An allocate reads and evaluates each block header visited before the fit, then writes 2 or 4
// tags and responds; a free also reads its right neighbor when the freed block is not the last.
// Items are taken one at a time, the pace being set by the walk through the tag memory.
// Reset: asynchronous, active low; afterwards the INIT0 and INIT1 states write the first and last
// heap tags, during which no item is accepted. The rest of the tag memory needs no clearing.
module boundary_tag_heap_allocator_unit #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bthalloc_pkg::req_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bthalloc_pkg::rsp_t out_o
);

  // The controller sequences the walk; the datapath holds the tag memory, the
  // walk pointers and the result register.
  bthalloc_pkg::cmd_t cmd;
  bthalloc_pkg::sts_t sts;

  bthalloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The request is sampled into the datapath on the accepting edge.
  bthalloc_dp #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (out_o)
  );

endmodule

[sim/tb_boundary_tag_heap_allocator_unit.sv]
module tb_boundary_tag_heap_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HeapBytes = 4096;
  localparam int HeapSpan  = HeapBytes & ~7;
  localparam int WordCount = HeapBytes / 4;
  localparam int MinSize   = 8;
  localparam int NumRandom = 730;

  // Keeps its own copy of the tag memory and the queue of responses that
  // the block still owes. Payload offsets of live blocks are tracked so the
  // stimulus can free real allocations.
  class heap_scoreboard;
    logic [31:0]        tags[WordCount];
    bthalloc_pkg::rsp_t owed[$];
    logic [11:0]        live[$];
    int                 errors;

    function new();
      errors = 0;
      foreach (tags[i]) tags[i] = '0;
      put_tags(0, HeapSpan, 1'b0);
    endfunction

    function logic [31:0] get_tag(int unsigned off);
      return (off / 4 < WordCount) ? tags[off / 4] : 32'd0;
    endfunction

    function void put_tags(int unsigned start, int unsigned size, logic used);
      int unsigned v;
      v = size | used;
      if (start / 4 < WordCount) tags[start / 4] = v;
      if ((start + size - 4) / 4 < WordCount) tags[(start + size - 4) / 4] = v;
    endfunction

    // First fit over the implicit block chain; the tail is split off only
    // when more than two minimum blocks' worth of bytes would remain.
    function bthalloc_pkg::rsp_t allocate(int unsigned want);
      bthalloc_pkg::rsp_t r;
      int unsigned        need, pos, h, sz;
      need = (want + MinSize + 7) & ~7;
      pos  = 0;
      r    = '{payload_offset: '0, status: bthalloc_pkg::ST_NO_FIT};
      while (pos < HeapSpan) begin
        h  = get_tag(pos);
        sz = h & ~7;
        if (sz == 0 || sz > HeapSpan - pos) break;
        if (!h[0] && sz >= need) begin
          if (sz > need + 2 * MinSize) begin
            put_tags(pos, need, 1'b1);
            put_tags(pos + need, sz - need, 1'b0);
          end else begin
            put_tags(pos, sz, 1'b1);
          end
          r.payload_offset = 12'(pos + 4);
          r.status = bthalloc_pkg::ST_OK;
          live.push_back(r.payload_offset);
          return r;
        end
        pos += sz;
      end
      return r;
    endfunction

    // Release with coalescing on both sides; any address that is not the
    // payload of a used block in the chain leaves the heap untouched.
    function bthalloc_pkg::rsp_t release_block(int unsigned p);
      bthalloc_pkg::rsp_t r;
      int unsigned        target, pos, prev, sz, h, start, size, nh, nsz;
      bit                 have_prev, prev_free, found;
      r = '{payload_offset: '0, status: bthalloc_pkg::ST_BAD_ADDR};
      pos = 0; prev = 0; sz = 0;
      have_prev = 0; prev_free = 0; found = 0;
      if (p < 4 || ((p - 4) & 7) != 0 || p >= HeapSpan) return r;
      target = p - 4;
      while (pos < HeapSpan) begin
        h  = get_tag(pos);
        sz = h & ~7;
        if (sz == 0 || sz > HeapSpan - pos) return r;
        if (pos == target) begin
          found = h[0];
          break;
        end
        if (pos > target) return r;
        prev = pos;
        have_prev = 1;
        prev_free = !h[0];
        pos += sz;
      end
      if (!found) return r;
      start = target;
      size  = sz;
      if (have_prev && prev_free) begin
        start = prev;
        size += target - prev;
      end
      if (target + sz < HeapSpan) begin
        nh  = get_tag(target + sz);
        nsz = nh & ~7;
        if (!nh[0] && nsz != 0 && nsz <= HeapSpan - (target + sz)) size += nsz;
      end
      put_tags(start, size, 1'b0);
      foreach (live[i]) begin
        if (live[i] == p[11:0]) begin
          live.delete(i);
          break;
        end
      end
      r.status = bthalloc_pkg::ST_OK;
      return r;
    endfunction

    function void note_request(bthalloc_pkg::req_t q);
      if (q.req_type == bthalloc_pkg::REQ_ALLOC) owed.push_back(allocate(q.request_size));
      else owed.push_back(release_block(q.release_offset));
    endfunction

    function void check_response(bthalloc_pkg::rsp_t got);
      bthalloc_pkg::rsp_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected response %h", $realtime, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.payload_offset !== want.payload_offset) begin
        $display("%0t: payload_offset expected %0d actual %0d", $realtime,
                 want.payload_offset, got.payload_offset);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  bthalloc_pkg::req_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  bthalloc_pkg::rsp_t out_o;

  heap_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  boundary_tag_heap_allocator_unit #(.HEAP_BYTES(HeapBytes)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o
  );

  // Most items go back to back; every fourth one or so waits a while.
  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
  endfunction

  // Valid drops only when a gap follows, so back-to-back items keep it high.
  task automatic send_item(bthalloc_pkg::req_t q);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(q);
  endtask

  task automatic send_alloc(int unsigned size);
    send_item('{req_type: bthalloc_pkg::REQ_ALLOC, request_size: size[12:0],
                release_offset: '0});
  endtask

  task automatic send_free(int unsigned off);
    send_item('{req_type: bthalloc_pkg::REQ_FREE, request_size: '0,
                release_offset: off[11:0]});
  endtask

  // The receiver sometimes holds ready low for a random stretch before taking an item.
  initial begin
    @(posedge rst_ni);
    forever begin
      int stall;
      stall = draw_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_response(out_o);
    end
  end

  initial begin
    #100ms;
    $display("boundary_tag_heap_allocator_unit: mismatch");
    $finish;
  end

  initial begin
    int unsigned kind, sz;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: the oversized request, the whole heap, zero bytes,
    // every flavor of bad address, a double free and a merge with a free left neighbor.
    send_alloc(4096);
    send_alloc(8191);
    send_alloc(HeapSpan - 8);
    send_free(4);
    send_free(4);
    send_alloc(0);
    send_alloc(1);
    send_alloc(16);
    send_alloc(24);
    send_alloc(100);
    send_free(0);
    send_free(3);
    send_free(8);
    send_free(4095);
    send_free(4092);
    send_free(2052);
    send_free(20);
    send_free(12);
    send_free(28);
    send_free(12);
    send_alloc(4000);
    send_alloc(4);
    send_free(4);

    // Random part: mostly allocations and frees of live blocks, with some
    // random offsets mixed in as noise.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.owed.size() != 0) @(posedge clk_i);
      end
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        sz = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 200);
        send_alloc(sz);
      end else if (kind < 9 && sb.live.size() != 0) begin
        send_free(sb.live[$urandom_range(0, sb.live.size() - 1)]);
      end else begin
        send_free($urandom_range(0, 4095));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("boundary_tag_heap_allocator_unit: match");
    end else begin
      $display("boundary_tag_heap_allocator_unit: mismatch");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/bthalloc_pkg.sv
src/bthalloc_ram.sv
src/bthalloc_dp.sv
src/bthalloc_ctrl.sv
src/boundary_tag_heap_allocator_unit.sv
sim/tb_boundary_tag_heap_allocator_unit.sv
